@@ rtl/csh_pkg.sv @@
// ----------------------------------------------------------------------------
// csh_pkg
// Shared types and codes for the capsule / sphere hit test pipeline.
// ----------------------------------------------------------------------------
package csh_pkg;

    localparam logic [1:0] SEL_TOP = 2'd0;
    localparam logic [1:0] SEL_BOT = 2'd1;
    localparam logic [1:0] SEL_MID = 2'd2;

    typedef struct packed {
        logic valid;
        logic zero_len;
    } t_div_ctl;

endpackage

@@ rtl/csh_div.sv @@
// ----------------------------------------------------------------------------
// csh_div
// Pipelined restoring divider, one quotient bit per stage, with several
// lanes sharing one divisor. Side data travels alongside each item.
// ----------------------------------------------------------------------------
module csh_div #(
    parameter int NW    = 77,
    parameter int DW    = 52,
    parameter int QW    = 25,
    parameter int SW    = 8,
    parameter int LANES = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  csh_pkg::t_div_ctl                i_ctl,
    input  logic [LANES-1:0][NW-1:0]         i_num,
    input  logic [DW-1:0]                    i_den,
    input  logic [SW-1:0]                    i_side,
    output csh_pkg::t_div_ctl                o_ctl,
    output logic [LANES-1:0][QW-1:0]         o_quo,
    output logic [SW-1:0]                    o_side
);

    csh_pkg::t_div_ctl               r_ctl  [0:QW];
    logic [LANES-1:0][DW-1:0]        r_rem  [0:QW];
    logic [LANES-1:0][QW-1:0]        r_low  [0:QW];
    logic [LANES-1:0][QW-1:0]        r_quo  [0:QW];
    logic [DW-1:0]                   r_den  [0:QW];
    logic [SW-1:0]                   r_side [0:QW];

    logic [LANES-1:0][DW-1:0]        n_rem  [1:QW];
    logic [LANES-1:0][QW-1:0]        n_low  [1:QW];
    logic [LANES-1:0][QW-1:0]        n_quo  [1:QW];

    always_comb begin
        logic [DW:0] t;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < LANES; l++) begin
                t = {r_rem[k][l], r_low[k][l][QW-1]};
                n_low[k+1][l] = {r_low[k][l][QW-2:0], 1'b0};
                if (t >= {1'b0, r_den[k]}) begin
                    n_rem[k+1][l] = DW'(t - {1'b0, r_den[k]});
                    n_quo[k+1][l] = {r_quo[k][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[k+1][l] = t[DW-1:0];
                    n_quo[k+1][l] = {r_quo[k][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k <= QW; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_rem[0][l] <= DW'(i_num[l] >> QW);
            r_low[0][l] <= i_num[l][QW-1:0];
            r_quo[0][l] <= '0;
        end
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int k = 1; k <= QW; k++) begin
            r_rem[k]  <= n_rem[k];
            r_low[k]  <= n_low[k];
            r_quo[k]  <= n_quo[k];
            r_den[k]  <= r_den[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_ctl  = r_ctl[QW];
    assign o_quo  = r_quo[QW];
    assign o_side = r_side[QW];

endmodule

@@ rtl/capsule_sphere_hit_test_top.sv @@
// ----------------------------------------------------------------------------
// capsule_sphere_hit_test_top
// Capsule / sphere overlap test on signed fixed point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the capsule axis end points, capsule radius, sphere center and
//   sphere radius on the i_ ports and raise start. An item is taken at every
//   rising edge where start is high and busy is low; busy stays low, so
//   one item per cycle is sustained.
//   Each item yields one result: o_hit is valid for exactly one cycle while
//   o_done is high. Results leave in the order items came in.
//   The projection divider resolves one quotient bit per stage over
//   COORD_WIDTH + 1 stages; the other stages cover the differences,
//   products, dot sums, dot magnitude, numerator products, nearest axis
//   point, offsets, squares and distance check.
//   A synchronous active-low reset clears all valid bits; items in flight are
//   dropped. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module capsule_sphere_hit_test_top #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] i_cyl_top_x,
    input  logic [COORD_WIDTH-1:0] i_cyl_top_y,
    input  logic [COORD_WIDTH-1:0] i_cyl_top_z,
    input  logic [COORD_WIDTH-1:0] i_cyl_bot_x,
    input  logic [COORD_WIDTH-1:0] i_cyl_bot_y,
    input  logic [COORD_WIDTH-1:0] i_cyl_bot_z,
    input  logic [COORD_WIDTH-2:0] i_cyl_radius,
    input  logic [COORD_WIDTH-1:0] i_sph_x,
    input  logic [COORD_WIDTH-1:0] i_sph_y,
    input  logic [COORD_WIDTH-1:0] i_sph_z,
    input  logic [COORD_WIDTH-2:0] i_sph_radius,
    output logic                   o_done,
    output logic                   o_hit
);

    localparam int W   = COORD_WIDTH;
    localparam int MW  = W + 1;
    localparam int PW  = 2 * MW;
    localparam int LW  = PW + 2;
    localparam int NW  = LW + MW;
    localparam int QW  = W + 1;
    localparam int DLO = LW / 2;
    localparam int DHI = LW - DLO;
    localparam int PPW = W + 3;
    localparam int EW  = W + 4;
    localparam int SQW = 2 * EW;
    localparam int DSW = SQW + 2;

    typedef struct packed {
        logic [1:0]          sel;
        logic [2:0]          asgn;
        logic                dneg;
        logic [2:0][W-1:0]   top;
        logic [2:0][W-1:0]   bot;
        logic [2:0][W-1:0]   c;
        logic [W-1:0]        rs;
    } t_side;

    localparam int SW = $bits(t_side);

    logic [2:0][W-1:0] in_top;
    logic [2:0][W-1:0] in_bot;
    logic [2:0][W-1:0] in_c;

    assign in_top = {i_cyl_top_z, i_cyl_top_y, i_cyl_top_x};
    assign in_bot = {i_cyl_bot_z, i_cyl_bot_y, i_cyl_bot_x};
    assign in_c   = {i_sph_z, i_sph_y, i_sph_x};
    assign busy   = 1'b0;

    // stage 1: differences and segment select
    logic              r1_valid;
    logic [1:0]        r1_sel;
    logic [2:0][MW-1:0] r1_amag, r1_vmag;
    logic [2:0]        r1_asgn, r1_vsgn;
    logic [2:0][W-1:0] r1_top, r1_bot, r1_c;
    logic [W-1:0]      r1_rs;

    logic [1:0]         n1_sel;
    logic [2:0][MW-1:0] n1_amag, n1_vmag;
    logic [2:0]         n1_asgn, n1_vsgn;

    always_comb begin
        logic [MW-1:0] da, dv;
        for (int i = 0; i < 3; i++) begin
            da = {in_bot[i][W-1], in_bot[i]} - {in_top[i][W-1], in_top[i]};
            dv = {in_c[i][W-1], in_c[i]} - {in_top[i][W-1], in_top[i]};
            n1_asgn[i] = da[MW-1];
            n1_vsgn[i] = dv[MW-1];
            n1_amag[i] = da[MW-1] ? -da : da;
            n1_vmag[i] = dv[MW-1] ? -dv : dv;
        end
        priority if ($signed(i_sph_y) > $signed(i_cyl_top_y)) begin
            n1_sel = csh_pkg::SEL_TOP;
        end else if ($signed(i_sph_y) < $signed(i_cyl_bot_y)) begin
            n1_sel = csh_pkg::SEL_BOT;
        end else begin
            n1_sel = csh_pkg::SEL_MID;
        end
    end

    // stage 2: products
    logic               r2_valid;
    logic [2:0][PW-1:0] r2_av, r2_aa;
    logic [2:0]         r2_neg;
    logic [1:0]         r2_sel;
    logic [2:0][MW-1:0] r2_amag;
    logic [2:0]         r2_asgn;
    logic [2:0][W-1:0]  r2_top, r2_bot, r2_c;
    logic [W-1:0]       r2_rs;

    // stage 3: dot sums and squared axis length
    logic               r3_valid;
    logic [LW-1:0]      r3_pos, r3_neg, r3_len;
    logic [1:0]         r3_sel;
    logic [2:0][MW-1:0] r3_amag;
    logic [2:0]         r3_asgn;
    logic [2:0][W-1:0]  r3_top, r3_bot, r3_c;
    logic [W-1:0]       r3_rs;

    logic [LW-1:0] n3_pos, n3_neg, n3_len;

    always_comb begin
        n3_pos = '0;
        n3_neg = '0;
        n3_len = '0;
        for (int i = 0; i < 3; i++) begin
            if (r2_neg[i]) begin
                n3_neg = n3_neg + LW'(r2_av[i]);
            end else begin
                n3_pos = n3_pos + LW'(r2_av[i]);
            end
            n3_len = n3_len + LW'(r2_aa[i]);
        end
    end

    // stage 4: signed dot magnitude
    logic               r4_valid;
    logic [LW-1:0]      r4_dmag, r4_len;
    logic               r4_dneg, r4_zero;
    logic [1:0]         r4_sel;
    logic [2:0][MW-1:0] r4_amag;
    logic [2:0]         r4_asgn;
    logic [2:0][W-1:0]  r4_top, r4_bot, r4_c;
    logic [W-1:0]       r4_rs;

    // stage 5: numerator partial products
    logic                       r5_valid;
    logic                       r5_zero;
    logic [LW-1:0]              r5_len;
    logic [2:0][DLO+MW-1:0]     r5_plo;
    logic [2:0][DHI+MW-1:0]     r5_phi;
    t_side                      r5_side;

    logic [2:0][NW-1:0] div_num;
    csh_pkg::t_div_ctl  div_in_ctl, div_out_ctl;
    logic [2:0][QW-1:0] div_quo;
    logic [SW-1:0]      div_side_bits;
    t_side              div_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_num[i] = (NW'(r5_phi[i]) << DLO) + NW'(r5_plo[i]);
        end
        div_in_ctl.valid    = r5_valid;
        div_in_ctl.zero_len = r5_zero;
    end

    csh_div #(
        .NW    (NW),
        .DW    (LW),
        .QW    (QW),
        .SW    (SW),
        .LANES (3)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_in_ctl),
        .i_num   (div_num),
        .i_den   (r5_len),
        .i_side  (r5_side),
        .o_ctl   (div_out_ctl),
        .o_quo   (div_quo),
        .o_side  (div_side_bits)
    );

    assign div_side = t_side'(div_side_bits);

    // stage 7: nearest axis point
    logic                r7_valid;
    logic [2:0][PPW-1:0] r7_p;
    logic [2:0][W-1:0]   r7_c;
    logic [W-1:0]        r7_rs;

    logic [2:0][PPW-1:0] n7_p;

    always_comb begin
        logic [PPW-1:0] tx, bx, qx;
        for (int i = 0; i < 3; i++) begin
            tx = {{3{div_side.top[i][W-1]}}, div_side.top[i]};
            bx = {{3{div_side.bot[i][W-1]}}, div_side.bot[i]};
            qx = {2'b00, div_quo[i]};
            unique case (div_side.sel)
                csh_pkg::SEL_TOP: n7_p[i] = tx;
                csh_pkg::SEL_BOT: n7_p[i] = bx;
                csh_pkg::SEL_MID: begin
                    if (div_out_ctl.zero_len) begin
                        n7_p[i] = tx;
                    end else if (div_side.dneg != div_side.asgn[i]) begin
                        n7_p[i] = tx - qx;
                    end else begin
                        n7_p[i] = tx + qx;
                    end
                end
                default: n7_p[i] = tx;
            endcase
        end
    end

    // stage 8: offsets, stage 9: squares
    logic               r8_valid;
    logic [2:0][EW-1:0] r8_emag;
    logic [W-1:0]       r8_rs;

    logic [2:0][EW-1:0] n8_emag;

    always_comb begin
        logic [EW-1:0] e;
        for (int i = 0; i < 3; i++) begin
            e = {r7_p[i][PPW-1], r7_p[i]} - {{4{r7_c[i][W-1]}}, r7_c[i]};
            n8_emag[i] = e[EW-1] ? -e : e;
        end
    end

    logic                r9_valid;
    logic [2:0][SQW-1:0] r9_esq;
    logic [2*W-1:0]      r9_rs2;

    logic [DSW-1:0] n10_dist;

    assign n10_dist = DSW'(r9_esq[0]) + DSW'(r9_esq[1]) + DSW'(r9_esq[2]);

    logic r_done, r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r1_valid <= start & ~busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r7_valid <= div_out_ctl.valid;
            r8_valid <= r7_valid;
            r9_valid <= r8_valid;
            r_done   <= r9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sel  <= n1_sel;
        r1_amag <= n1_amag;
        r1_vmag <= n1_vmag;
        r1_asgn <= n1_asgn;
        r1_vsgn <= n1_vsgn;
        r1_top  <= in_top;
        r1_bot  <= in_bot;
        r1_c    <= in_c;
        r1_rs   <= {1'b0, i_cyl_radius} + {1'b0, i_sph_radius};

        for (int i = 0; i < 3; i++) begin
            r2_av[i] <= PW'(r1_amag[i]) * PW'(r1_vmag[i]);
            r2_aa[i] <= PW'(r1_amag[i]) * PW'(r1_amag[i]);
        end
        r2_neg  <= r1_asgn ^ r1_vsgn;
        r2_sel  <= r1_sel;
        r2_amag <= r1_amag;
        r2_asgn <= r1_asgn;
        r2_top  <= r1_top;
        r2_bot  <= r1_bot;
        r2_c    <= r1_c;
        r2_rs   <= r1_rs;

        r3_pos  <= n3_pos;
        r3_neg  <= n3_neg;
        r3_len  <= n3_len;
        r3_sel  <= r2_sel;
        r3_amag <= r2_amag;
        r3_asgn <= r2_asgn;
        r3_top  <= r2_top;
        r3_bot  <= r2_bot;
        r3_c    <= r2_c;
        r3_rs   <= r2_rs;

        if (r3_pos >= r3_neg) begin
            r4_dmag <= r3_pos - r3_neg;
            r4_dneg <= 1'b0;
        end else begin
            r4_dmag <= r3_neg - r3_pos;
            r4_dneg <= 1'b1;
        end
        r4_len  <= r3_len;
        r4_zero <= (r3_len == '0);
        r4_sel  <= r3_sel;
        r4_amag <= r3_amag;
        r4_asgn <= r3_asgn;
        r4_top  <= r3_top;
        r4_bot  <= r3_bot;
        r4_c    <= r3_c;
        r4_rs   <= r3_rs;

        for (int i = 0; i < 3; i++) begin
            r5_plo[i] <= (DLO+MW)'(r4_dmag[DLO-1:0]) * (DLO+MW)'(r4_amag[i]);
            r5_phi[i] <= (DHI+MW)'(r4_dmag[LW-1:DLO]) * (DHI+MW)'(r4_amag[i]);
        end
        r5_zero      <= r4_zero;
        r5_len       <= r4_len;
        r5_side.sel  <= r4_sel;
        r5_side.asgn <= r4_asgn;
        r5_side.dneg <= r4_dneg;
        r5_side.top  <= r4_top;
        r5_side.bot  <= r4_bot;
        r5_side.c    <= r4_c;
        r5_side.rs   <= r4_rs;

        r7_p  <= n7_p;
        r7_c  <= div_side.c;
        r7_rs <= div_side.rs;

        r8_emag <= n8_emag;
        r8_rs   <= r7_rs;

        for (int i = 0; i < 3; i++) begin
            r9_esq[i] <= SQW'(r8_emag[i]) * SQW'(r8_emag[i]);
        end
        r9_rs2 <= (2*W)'(r8_rs) * (2*W)'(r8_rs);

        r_hit <= (n10_dist <= DSW'(r9_rs2));
    end

    assign o_done = r_done;
    assign o_hit  = r_hit;

endmodule
